[rtl/lfsr_keystream_byte_cipher_assert.svh]
// Assertion macros shared by the keystream cipher RTL.
`ifndef LFSR_KEYSTREAM_BYTE_CIPHER_ASSERT_SVH
`define LFSR_KEYSTREAM_BYTE_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked outside reset.
`define LKBC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every edge, reset included.
`define LKBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LKBC_ASSERT(lbl, clk, rst, prop, msg)
`define LKBC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/lkbc_pkg.sv]
// Shared types and constants for the LFSR keystream byte cipher.
package lkbc_pkg;

  // Keystream bits consumed per byte
  localparam int WORD_BITS = 8;
  // Width of register-length and bit-count values (holds up to 64)
  localparam int LEN_W = 7;
  // Entries in the request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic REG_TAP_MASK   = 1'b0;
  localparam logic REG_SEED_VALUE = 1'b1;

  // One queued request
  typedef struct packed {
    logic [WORD_BITS-1:0] data;
    logic                 start;
  } queue_item_t;

  // Configuration events seen by the back end
  typedef struct packed {
    logic seed_load;
    logic word_drop;
  } cfg_ctl_t;

endpackage

[rtl/lkbc_cfg.sv]
// Configuration registers: tap mask and derived register length.
module lkbc_cfg #(
  parameter int STATE_BITS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [STATE_BITS-1:0]    cfg_data,
  output logic [STATE_BITS-1:0]    tap_mask,
  output logic [lkbc_pkg::LEN_W-1:0] reg_len,
  output lkbc_pkg::cfg_ctl_t       cfg_ctl
);
  import lkbc_pkg::*;

  localparam int LOGW = $clog2(STATE_BITS);
  localparam logic [STATE_BITS-1:0] TAP_RESET = STATE_BITS'(184);

  // Register length: one past the highest set tap, never below one byte
  function automatic logic [LEN_W-1:0] reg_length(input logic [STATE_BITS-1:0] m);
    logic [STATE_BITS-1:0] v;
    logic [LEN_W-1:0]      pos;
    v   = m;
    pos = '0;
    for (int k = LOGW - 1; k >= 0; k--) begin
      if ((v >> (1 << k)) != '0) begin
        pos = pos + LEN_W'(1 << k);
        v   = v >> (1 << k);
      end
    end
    if (pos < LEN_W'(WORD_BITS - 1)) begin
      return LEN_W'(WORD_BITS);
    end
    return pos + LEN_W'(1);
  endfunction

  // Decode write strobes
  always_comb begin
    cfg_ctl.seed_load = cfg_we && (cfg_index == REG_SEED_VALUE);
    cfg_ctl.word_drop = cfg_we && (cfg_index == REG_TAP_MASK);
  end

  // Hold tap mask and its length
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_mask <= TAP_RESET;
      reg_len  <= reg_length(TAP_RESET);
    end else if (cfg_ctl.word_drop) begin
      tap_mask <= cfg_data;
      reg_len  <= reg_length(cfg_data);
    end
  end

endmodule

[rtl/lkbc_front.sv]
// Front end: accepts requests and queues them for the back end.
module lkbc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lkbc_pkg::WORD_BITS-1:0]     data_byte,
  input  logic                               start_message,
  output logic                               q_valid,
  output lkbc_pkg::queue_item_t              q_item,
  input  logic                               q_pop
);
  import lkbc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_item_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wptr;
  logic [PTR_W-1:0]     rptr;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 push;
  queue_item_t          item;

  // Tag the request with its message-start flag
  assign item.data  = data_byte;
  assign item.start = start_message;

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = mem[rptr];

  // Track fill level
  always_comb begin
    case ({push, q_pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (q_pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Store request payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= item;
    end
  end

endmodule

[rtl/lkbc_back.sv]
// Back end: steps the LFSR, builds the keystream byte and holds the result.
module lkbc_back #(
  parameter int STATE_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  lkbc_pkg::queue_item_t          q_item,
  output logic                           q_pop,
  input  lkbc_pkg::cfg_ctl_t             cfg_ctl,
  input  logic [STATE_BITS-1:0]          seed_data,
  input  logic [STATE_BITS-1:0]          tap_mask,
  input  logic [lkbc_pkg::LEN_W-1:0]     reg_len,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lkbc_pkg::WORD_BITS-1:0] cipher_byte
);
  import lkbc_pkg::*;

  localparam int IDX_W = (STATE_BITS > 1) ? $clog2(STATE_BITS) : 1;

  logic [STATE_BITS-1:0] lfsr_word;
  logic [LEN_W-1:0]      bits_left;
  logic                  word_loaded;

  logic [STATE_BITS-1:0] lowmask;
  logic [STATE_BITS-1:0] topbit;
  logic [STATE_BITS-1:0] masked;
  logic [STATE_BITS-1:0] adv;
  logic [STATE_BITS-1:0] src;
  logic [STATE_BITS-1:0] lfsr_word_next;
  logic [LEN_W-1:0]      cur_bl;
  logic [LEN_W-1:0]      bits_left_next;
  logic                  fb;
  logic                  draw;
  logic                  span;
  logic [WORD_BITS-1:0]  key;
  logic [7:0]            pos  [WORD_BITS];
  logic [7:0]            wrap [WORD_BITS];

  // Take the next request when the result register frees up
  assign q_pop = q_valid && (!out_valid || out_ready);

  // One LFSR step from the current word
  always_comb begin
    for (int i = 0; i < STATE_BITS; i++) begin
      lowmask[i] = (LEN_W'(i) < reg_len);
    end
    topbit = lowmask ^ (lowmask >> 1);
    masked = lfsr_word & lowmask;
    fb     = ^(masked & tap_mask);
    adv    = (masked >> 1) | (fb ? topbit : '0);
  end

  // Pick keystream bits: fresh word, tail plus head of next, or plain tail
  always_comb begin
    draw   = q_item.start || !word_loaded || (bits_left == '0);
    span   = !draw && (bits_left < LEN_W'(WORD_BITS));
    cur_bl = draw ? reg_len : bits_left;
    src    = draw ? adv : lfsr_word;
    for (int i = 0; i < WORD_BITS; i++) begin
      pos[i]  = {1'b0, cur_bl} + 8'(i) - 8'(WORD_BITS);
      wrap[i] = {1'b0, reg_len} + pos[i];
      if (pos[i][7]) begin
        key[i] = adv[wrap[i][IDX_W-1:0]];
      end else begin
        key[i] = src[pos[i][IDX_W-1:0]];
      end
    end
    if (span) begin
      bits_left_next = reg_len - LEN_W'(WORD_BITS) + bits_left;
    end else begin
      bits_left_next = cur_bl - LEN_W'(WORD_BITS);
    end
    lfsr_word_next = (draw || span) ? adv : lfsr_word;
  end

  // Hold LFSR state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_word   <= STATE_BITS'(1);
      bits_left   <= '0;
      word_loaded <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_ctl.seed_load) begin
        lfsr_word   <= seed_data;
        bits_left   <= '0;
        word_loaded <= 1'b0;
      end else if (cfg_ctl.word_drop) begin
        word_loaded <= 1'b0;
      end else if (q_pop) begin
        lfsr_word   <= lfsr_word_next;
        bits_left   <= bits_left_next;
        word_loaded <= 1'b1;
      end
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the result byte
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cipher_byte <= q_item.data ^ key;
    end
  end

endmodule

[rtl/lfsr_keystream_byte_cipher.sv]
// Top level of the LFSR keystream byte cipher.
//
//   channel   handshake            payload
//   input     in_valid/in_ready    data_byte[7:0], start_message
//   output    out_valid/out_ready  cipher_byte[7:0]
//   config    cfg_we               cfg_index, cfg_data[STATE_BITS-1:0]
//
// One byte per cycle while the output is not stalled; an accepted byte is held in
// the two-entry request queue ahead of the LFSR until the back end pops it into the result register.
// At most one LFSR step is taken per byte, in the cycle the back end pops it.
// Reset is synchronous and restores taps 184, seed 1 and an empty queue.
// A stalled output fills the queue; in_ready drops once both entries are held.
module lfsr_keystream_byte_cipher #(
  parameter int STATE_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lkbc_pkg::WORD_BITS-1:0] data_byte,
  input  logic                           start_message,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lkbc_pkg::WORD_BITS-1:0] cipher_byte,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [STATE_BITS-1:0]          cfg_data
);
  import lkbc_pkg::*;

  `include "lfsr_keystream_byte_cipher_assert.svh"

  logic                  q_valid;
  logic                  q_pop;
  queue_item_t           q_item;
  cfg_ctl_t              cfg_ctl;
  logic [STATE_BITS-1:0] tap_mask;
  logic [LEN_W-1:0]      reg_len;

  // Configuration registers
  lkbc_cfg #(
    .STATE_BITS(STATE_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .tap_mask (tap_mask),
    .reg_len  (reg_len),
    .cfg_ctl  (cfg_ctl)
  );

  // Request intake and queue
  lkbc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .start_message(start_message),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // Keystream and result
  lkbc_back #(
    .STATE_BITS(STATE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .cfg_ctl    (cfg_ctl),
    .seed_data  (cfg_data),
    .tap_mask   (tap_mask),
    .reg_len    (reg_len),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cipher_byte(cipher_byte)
  );

  // Checks
  `LKBC_ASSERT_ALWAYS(a_reset_clears_out, clk, $past(rst) |-> !out_valid, "valid after reset")
  `LKBC_ASSERT(a_pop_needs_entry, clk, rst, q_pop |-> q_valid, "queue popped while empty")
  `LKBC_ASSERT(a_push_lands, clk, rst, in_valid && in_ready && !q_valid |=> q_valid, "request lost")
  `LKBC_ASSERT(a_len_at_least_byte, clk, rst, reg_len >= LEN_W'(WORD_BITS), "length below a byte")

endmodule

[verif/tb.sv]
// Self-checking testbench for the LFSR keystream byte cipher against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkbc_pkg::*;

  localparam int KEY_BITS = 64;
  localparam int PHASES = 13;
  localparam int PHASE_BYTES = 150;
  localparam int HOLD_CYCLES = 80;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [WORD_BITS-1:0] data_byte;
  logic                 start_message;
  logic                 out_valid;
  logic                 out_ready;
  logic [WORD_BITS-1:0] cipher_byte;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [KEY_BITS-1:0]  cfg_data;

  // Predictor state: registers and keystream position
  logic [KEY_BITS-1:0]  cur_taps;
  logic [KEY_BITS-1:0]  cur_seed;
  logic [KEY_BITS-1:0]  ks_word;
  int                   ks_bits_left;
  bit                   ks_loaded;

  logic [WORD_BITS-1:0] cipher_q[$];
  int                   errors;

  // Sender burst control and receiver stall control
  bit                   gaps_on;
  int                   burst_left;
  rx_mode_t             rx_mode;
  int                   hold_req;
  int                   hold_seen;
  int                   hold_count;
  logic [15:0]          rx_pattern;

  lfsr_keystream_byte_cipher #(.STATE_BITS(KEY_BITS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .start_message(start_message),
    .out_valid(out_valid), .out_ready(out_ready), .cipher_byte(cipher_byte),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [KEY_BITS-1:0] low_mask(int k);
    return (k >= KEY_BITS) ? '1 : ((64'd1 << k) - 64'd1);
  endfunction

  // Register length: index of highest tap plus one, never below a byte
  function automatic int reg_length(logic [KEY_BITS-1:0] taps);
    int n;
    n = WORD_BITS;
    for (int b = 0; b < KEY_BITS; b++)
      if (taps[b] && b + 1 > n) n = b + 1;
    return n;
  endfunction

  function automatic logic [KEY_BITS-1:0] lfsr_step(logic [KEY_BITS-1:0] s, int n);
    logic [KEY_BITS-1:0] v;
    logic                fb;
    v = s & low_mask(n);
    fb = ^(v & cur_taps);
    return (64'(fb) << (n - 1)) | (v >> 1);
  endfunction

  // Advance the keystream by one byte and return the expected cipher byte
  function automatic logic [WORD_BITS-1:0] next_cipher_byte(logic [WORD_BITS-1:0] d,
                                                            logic s);
    int                  n;
    int                  need;
    logic [KEY_BITS-1:0] ks;
    n = reg_length(cur_taps);
    if (s || !ks_loaded || ks_bits_left == 0) begin
      ks_word = lfsr_step(ks_word, n);
      ks_bits_left = n;
      ks_loaded = 1'b1;
    end
    if (ks_bits_left < WORD_BITS) begin
      // byte spans the tail of this state and the head of the next
      need = WORD_BITS - ks_bits_left;
      ks = (ks_word & low_mask(ks_bits_left)) << need;
      ks_word = lfsr_step(ks_word, n);
      ks_bits_left = n - need;
      ks |= ks_word >> ks_bits_left;
    end else begin
      ks = ks_word >> (ks_bits_left - WORD_BITS);
      ks_bits_left -= WORD_BITS;
    end
    return d ^ ks[WORD_BITS-1:0];
  endfunction

  // Offer one request, hold it until accepted, then record its expected result
  task automatic send_byte(logic [WORD_BITS-1:0] d, logic s);
    in_valid = 1'b1;
    data_byte = d;
    start_message = s;
    do @(posedge clk); while (!in_ready);
    cipher_q.push_back(next_cipher_byte(d, s));
    @(negedge clk);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain;
    in_valid = 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register while idle and mirror it in the predictor
  task automatic write_reg(logic idx, logic [KEY_BITS-1:0] value);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    if (idx == REG_TAP_MASK) begin
      cur_taps = value;
      ks_loaded = 1'b0;
    end else begin
      cur_seed = value;
      ks_word = value;
      ks_bits_left = 0;
      ks_loaded = 1'b0;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Receiver: long hold-off on request, otherwise the current stall mode
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_count = HOLD_CYCLES;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        end
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (cipher_q.size() == 0) begin
        $error("cipher_byte: expected none, actual %02h", cipher_byte);
        errors++;
      end else begin
        if (cipher_byte !== cipher_q[0]) begin
          $error("cipher_byte: expected %02h, actual %02h", cipher_q[0], cipher_byte);
          errors++;
        end
        void'(cipher_q.pop_front());
      end
    end
  end

  // First bytes after reset with default taps and seed
  task automatic test_reset_state;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
  endtask

  // Register extremes, short registers, bytes spanning states, tap-only write
  task automatic test_register_extremes;
    write_reg(REG_TAP_MASK, 64'd128);
    write_reg(REG_SEED_VALUE, 64'd0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    write_reg(REG_SEED_VALUE, '1);
    write_reg(REG_TAP_MASK, '1);
    send_byte(8'hC3, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hFF, 1'b0);
    write_reg(REG_TAP_MASK, 64'h8000_0000_0000_0000);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b0);
    write_reg(REG_TAP_MASK, 64'h0000_0000_0000_1A01);
    write_reg(REG_SEED_VALUE, 64'h0000_0000_0000_1234);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h81, 1'b1);
    send_byte(8'h55, 1'b0);
    // keep the current state, draw afresh under new taps
    write_reg(REG_TAP_MASK, 64'd184);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b0);
  endtask

  // Output held off while input keeps coming, then a full drain
  task automatic test_backpressure;
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    write_reg(REG_SEED_VALUE, 64'hDEAD_BEEF_0BAD_F00D);
    hold_req++;
    for (int i = 0; i < 40; i++)
      send_byte(8'($urandom), ($urandom_range(0, 9) == 0));
    drain();
  endtask

  // Random registers and bytes under varied idling
  task automatic test_random_streams;
    int                  top;
    logic [KEY_BITS-1:0] taps;
    logic [KEY_BITS-1:0] seed;
    for (int p = 0; p < PHASES; p++) begin
      top = $urandom_range(0, 1) ? $urandom_range(7, 15) : $urandom_range(7, 63);
      taps = ({$urandom, $urandom} & low_mask(top)) | (64'd1 << top);
      case ($urandom_range(0, 5))
        0: seed = '0;
        1: seed = '1;
        default: seed = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 2))
        0: write_reg(REG_TAP_MASK, taps);
        1: write_reg(REG_SEED_VALUE, seed);
        default: begin
          write_reg(REG_SEED_VALUE, seed);
          write_reg(REG_TAP_MASK, taps);
        end
      endcase
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 24);
      for (int i = 0; i < PHASE_BYTES; i++)
        send_byte(8'($urandom), ($urandom_range(0, 11) == 0));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    start_message = 1'b0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TAP_MASK;
    cfg_data = '0;
    cur_taps = 64'd184;
    cur_seed = 64'd1;
    ks_word = 64'd1;
    ks_bits_left = 0;
    ks_loaded = 1'b0;
    errors = 0;
    gaps_on = 1'b1;
    burst_left = 3;
    rx_mode = RX_PATTERN;
    hold_req = 0;
    hold_seen = 0;
    hold_count = 0;
    rx_pattern = 16'b1101_0011_1000_1110;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_register_extremes();
    test_backpressure();
    test_random_streams();

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("[lfsr_keystream_byte_cipher] OK");
    else
      $display("[lfsr_keystream_byte_cipher] ERROR");
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("[lfsr_keystream_byte_cipher] ERROR");
    $finish;
  end

endmodule
